FILE: rtl/wret_pkg.sv
// ----------------------------------------------------------------------------
// wret_pkg
// Shared types and constants of the waypoint reached event tracker.
// ----------------------------------------------------------------------------
package wret_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;

  localparam logic [1:0] EXEC_NONE        = 2'd0;
  localparam logic [1:0] EXEC_NOT_STARTED = 2'd1;
  localparam logic [1:0] EXEC_ACTIVE      = 2'd2;
  localparam logic [1:0] EXEC_COMPLETE    = 2'd3;

  typedef struct packed {
    logic        status_loaded;
    logic        status_committed;
    logic [31:0] mission_gen;
    logic [15:0] item_count;
    logic [15:0] current_index;
    logic [1:0]  exec_state;
    logic        link_up;
  } in_word_t;

  typedef struct packed {
    logic [5:0] reached_index;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
    logic emit;
    logic advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_left;
    logic cand_here;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/wret_ctrl.sv
// ----------------------------------------------------------------------------
// wret_ctrl
// Sequencer: takes a snapshot, applies it, then walks the event scan.
// ----------------------------------------------------------------------------
module wret_ctrl import wret_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stat.any_left) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
      end
      ST_SCAN: begin
        if (stat.any_left) begin
          if (!stat.cand_here) begin
            cmd.advance = 1'b1;
          end else if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/wret_dp.sv
// ----------------------------------------------------------------------------
// wret_dp
// Tracking state, pending and sent masks, scan index and output register.
// ----------------------------------------------------------------------------
module wret_dp import wret_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  in_word_t             snap;
  logic                 tracking_valid;
  logic [31:0]          tracked_mission_gen;
  logic [IDX_W-1:0]     tracked_index;
  logic [1:0]           tracked_exec_state;
  logic [CAPACITY-1:0]  pending_mask;
  logic [CAPACITY-1:0]  sent_mask;
  logic [IDX_W-1:0]     idx;

  logic                 valid_snap;
  logic                 new_mission;
  logic                 restart;
  logic                 advance;
  logic                 completion;
  logic [CAPACITY-1:0]  adv_mask;
  logic [CAPACITY-1:0]  pending_next;
  logic [CAPACITY-1:0]  cand;
  logic [CAPACITY-1:0]  ge_mask;
  logic [CAPACITY-1:0]  gt_mask;
  logic                 link_en;

  // Snapshot classification.
  always_comb begin
    valid_snap = snap.status_committed && (snap.mission_gen != 32'd0) &&
                 (snap.item_count != 16'd0) &&
                 (snap.item_count <= 16'(CAPACITY)) &&
                 (snap.current_index < snap.item_count);
    new_mission = !tracking_valid || (tracked_mission_gen != snap.mission_gen);
    restart = (snap.exec_state inside {EXEC_NOT_STARTED, EXEC_ACTIVE}) &&
              ((tracked_exec_state == EXEC_COMPLETE) ||
               (snap.current_index < {10'd0, tracked_index}));
    advance = !restart && (tracked_exec_state == EXEC_ACTIVE) &&
              (snap.exec_state == EXEC_ACTIVE) &&
              (snap.current_index > {10'd0, tracked_index});
    completion = !restart && (snap.exec_state == EXEC_COMPLETE) &&
                 (tracked_exec_state != EXEC_COMPLETE);
  end

  // Skipped indices: from the tracked index up to, not including, the new one.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      adv_mask[i] = (IDX_W'(i) >= tracked_index) && (16'(i) < snap.current_index);
    end
    pending_next = pending_mask;
    if (advance) pending_next = pending_next | adv_mask;
    if (completion) begin
      pending_next[snap.current_index[IDX_W-1:0]] = 1'b1;
    end
  end

  // Scan view.
  always_comb begin
    link_en = snap.status_loaded && snap.link_up;
    cand    = link_en ? (pending_mask & ~sent_mask) : '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ge_mask[i] = IDX_W'(i) >= idx;
      gt_mask[i] = IDX_W'(i) > idx;
    end
    stat.any_left  = |(cand & ge_mask);
    stat.cand_here = cand[idx];
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) snap <= in_data;
    if (cmd.emit) begin
      out_data.reached_index <= idx;
      out_data.last_of_run   <= ~|(cand & gt_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_valid      <= 1'b0;
      tracked_mission_gen <= '0;
      tracked_index       <= '0;
      tracked_exec_state  <= EXEC_NONE;
      pending_mask        <= '0;
      sent_mask           <= '0;
      idx                 <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cmd.apply) begin
        idx <= '0;
        if (snap.status_loaded) begin
          if (!valid_snap) begin
            tracking_valid      <= 1'b0;
            tracked_mission_gen <= '0;
            tracked_index       <= '0;
            tracked_exec_state  <= EXEC_NONE;
            pending_mask        <= '0;
            sent_mask           <= '0;
          end else if (new_mission) begin
            tracking_valid      <= 1'b1;
            tracked_mission_gen <= snap.mission_gen;
            tracked_index       <= snap.current_index[IDX_W-1:0];
            tracked_exec_state  <= snap.exec_state;
            pending_mask        <= '0;
            sent_mask           <= '0;
          end else begin
            tracked_index      <= snap.current_index[IDX_W-1:0];
            tracked_exec_state <= snap.exec_state;
            if (restart) begin
              pending_mask <= '0;
              sent_mask    <= '0;
            end else begin
              pending_mask <= pending_next;
            end
          end
        end
      end else if (cmd.advance) begin
        idx <= idx + 1'b1;
      end

      if (cmd.emit) begin
        pending_mask[idx] <= 1'b0;
        sent_mask[idx]    <= 1'b1;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_marks_sent: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> sent_mask[$past(idx)] && !pending_mask[$past(idx)])
    else $error("emitted index not moved to sent");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("emit while output register is blocked");

  a_untracked_clean: assert property (@(posedge clk) disable iff (rst)
    !tracking_valid |-> (pending_mask == '0) && (sent_mask == '0) &&
                        (tracked_mission_gen == 32'd0))
    else $error("stale tracking state without a valid mission");

  a_emit_candidate: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cand[idx])
    else $error("emit of an index that is not a candidate");
`endif

endmodule

FILE: rtl/waypoint_reached_event_tracker.sv
// ----------------------------------------------------------------------------
// waypoint_reached_event_tracker
// Tracks mission progress from status snapshots and reports reached items.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word         Handshake
// in        input      in_word_t    in_valid / in_ready
// out       output     out_word_t   out_valid / out_ready
//
// A snapshot word is captured into a register and applied to the tracking
// state in the apply state. The scan then walks one mission index per cycle
// from zero up to the highest reached index that goes out, then sees that
// nothing is left and returns to idle; a stalled output holds the scan on its
// current index. Reset is synchronous and clears all tracking and the output
// valid flag. A new snapshot is taken once the previous scan is done, while
// the last result word may still wait in the output register.
//
module waypoint_reached_event_tracker import wret_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Command and status between the sequencer and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // The sequencer owns the input handshake and steps the scan.
  wret_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the masks and drives the output register.
  wret_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
